### sv/cbt_pkg.sv
// Shared types, constants and byte-class helpers for the CSS byte tokenizer.
`timescale 1ns / 1ps

package cbt_pkg;

  // Default widths of the position counters and the queue depth
  localparam int CBT_LINE_BITS   = 20;
  localparam int CBT_COLUMN_BITS = 16;
  localparam int CBT_OFFSET_BITS = 24;
  localparam int CBT_QUEUE_DEPTH = 4;
  localparam int KIND_BITS       = 4;

  // Token kinds as they appear on the result channel
  typedef enum logic [KIND_BITS-1:0] {
    TK_LBRACE = 4'd0,
    TK_RBRACE = 4'd1,
    TK_COLON  = 4'd2,
    TK_SEMI   = 4'd3,
    TK_COMMA  = 4'd4,
    TK_HASH   = 4'd5,
    TK_AT     = 4'd6,
    TK_STRING = 4'd7,
    TK_NUMBER = 4'd8,
    TK_IDENT  = 4'd9,
    TK_DELIM  = 4'd10,
    TK_EOF    = 4'd11
  } token_kind_t;

  // Lexer modes
  typedef enum logic [3:0] {
    LM_IDLE,
    LM_SLASH,
    LM_COMMENT,
    LM_STAR,
    LM_HASH,
    LM_AT,
    LM_NUMBER,
    LM_IDENT,
    LM_STRING,
    LM_ESCAPE
  } lex_mode_t;

  // Byte codes
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || is_alpha(b);
  endfunction

  // Tab, LF, VT, FF, CR and space
  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

### sv/css_byte_tokenizer_top.sv
// Top level of the CSS byte tokenizer: lexer front end, record queue, output back end.
`timescale 1ns / 1ps
//
// Input channel (in_valid/in_ready): one word is a text byte, or an end marker
// when in_end_of_text is high. Output channel (out_valid/out_ready): one word
// is one token with kind, start line/column, text offset/length and a flag on
// the last token caused by an input word.
// The lexer accepts one word per cycle while the record queue has room; each
// word produces zero, one or two tokens, queued as one record. The back end
// sends one token per cycle while the receiver is ready, so a word that
// yields two tokens sends them one after the other; sustained input rate is
// one word per cycle whenever the receiver is ready and the average token
// count per word stays at or below one. The queue is written at the edge that
// accepts the word; the output register then loads the token from the queue
// head once earlier tokens are out and the register is free.
// When the receiver stalls, the output register holds its word and the queue
// fills; in_ready drops only once all queue entries are taken.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the lexer to idle at line 1, column 1, offset 0. After an end
// marker the lexer returns to the same state on its own.
//
module css_byte_tokenizer_top
  import cbt_pkg::*;
#(
  parameter int LINE_BITS   = CBT_LINE_BITS,
  parameter int COLUMN_BITS = CBT_COLUMN_BITS,
  parameter int OFFSET_BITS = CBT_OFFSET_BITS,
  parameter int QUEUE_DEPTH = CBT_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_end_of_text,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   out_token_kind,
  output logic [LINE_BITS-1:0]   out_start_line,
  output logic [COLUMN_BITS-1:0] out_start_column,
  output logic [OFFSET_BITS-1:0] out_text_offset,
  output logic [OFFSET_BITS-1:0] out_text_length,
  output logic                   out_last_of_run
);

  localparam int SLOT_W = 1 + KIND_BITS + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS;
  localparam int REC_W  = 2 * SLOT_W;

  logic             step, push, pop, q_empty, q_full;
  logic [REC_W-1:0] push_rec, head_rec;

  assign in_ready = !q_full;
  assign step     = in_valid && in_ready;

  cbt_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .push        (push),
    .push_rec    (push_rec)
  );

  cbt_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .head_data (head_rec),
    .empty     (q_empty),
    .full      (q_full)
  );

  cbt_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (!q_empty),
    .head_rec         (head_rec),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_text_offset  (out_text_offset),
    .out_text_length  (out_text_length),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

### sv/cbt_front.sv
// Front end: lexer that classifies one byte a cycle, when stepped, into token records.
`timescale 1ns / 1ps

module cbt_front
  import cbt_pkg::*;
#(
  parameter int LINE_BITS   = CBT_LINE_BITS,
  parameter int COLUMN_BITS = CBT_COLUMN_BITS,
  parameter int OFFSET_BITS = CBT_OFFSET_BITS,
  localparam int SLOT_W     = 1 + KIND_BITS + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS,
  localparam int REC_W      = 2 * SLOT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  output logic             push,
  output logic [REC_W-1:0] push_rec
);

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);

  lex_mode_t               mode_r, mode_nxt;
  logic                    dq_r, dq_nxt;
  logic [LINE_BITS-1:0]    cur_line_r, cur_line_nxt;
  logic [COLUMN_BITS-1:0]  cur_col_r, cur_col_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt;
  logic [LINE_BITS-1:0]    tok_line_r, tok_line_nxt;
  logic [COLUMN_BITS-1:0]  tok_col_r, tok_col_nxt;
  logic [OFFSET_BITS-1:0]  tok_off_r, tok_off_nxt;
  logic [OFFSET_BITS-1:0]  tok_len_r, tok_len_nxt;

  logic                    e0, e1, run_idle, cont;
  token_kind_t             k0, k1, pend_kind;
  logic [OFFSET_BITS-1:0]  o1, n1, pos_inc, len_inc;
  logic [LINE_BITS-1:0]    line_inc;
  logic [COLUMN_BITS-1:0]  col_inc;
  logic                    quote_hit;

  // Saturating increments
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + OFF_ONE;
  assign len_inc  = (tok_len_r == '1) ? tok_len_r : tok_len_r + OFF_ONE;
  assign line_inc = (cur_line_r == '1) ? cur_line_r : cur_line_r + LINE_ONE;
  assign col_inc  = (cur_col_r == '1) ? cur_col_r : cur_col_r + COL_ONE;

  assign quote_hit = (text_byte == (dq_r ? CH_DQUOTE : CH_SQUOTE));

  // Kind of the pending multi-byte token for the current mode
  always_comb begin
    unique case (mode_r)
      LM_HASH:               pend_kind = TK_HASH;
      LM_AT:                 pend_kind = TK_AT;
      LM_NUMBER:             pend_kind = TK_NUMBER;
      LM_IDENT:              pend_kind = TK_IDENT;
      LM_STRING, LM_ESCAPE:  pend_kind = TK_STRING;
      default:               pend_kind = TK_DELIM;
    endcase
  end

  // Continuation test for hash, at-rule, number and identifier tokens
  always_comb begin
    unique case (mode_r)
      LM_AT:     cont = is_alnum(text_byte) || (text_byte == CH_MINUS);
      LM_NUMBER: cont = is_alnum(text_byte) || (text_byte == CH_DOT) ||
                        (text_byte == CH_PERCENT);
      default:   cont = is_alnum(text_byte) || (text_byte == CH_MINUS) ||
                        (text_byte == CH_UNDER);
    endcase
  end

  // Next state and emitted tokens; slot 0 is the pending token, slot 1 the new one
  always_comb begin
    mode_nxt     = mode_r;
    dq_nxt       = dq_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    pos_nxt      = pos_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_off_nxt  = tok_off_r;
    tok_len_nxt  = tok_len_r;
    e0           = 1'b0;
    k0           = pend_kind;
    e1           = 1'b0;
    k1           = TK_DELIM;
    o1           = pos_r;
    n1           = OFF_ONE;
    run_idle     = 1'b0;

    if (end_of_text) begin
      // Flush pending token, then end-of-file; all state back to reset values
      e0           = (mode_r != LM_IDLE) && (mode_r != LM_COMMENT) && (mode_r != LM_STAR);
      e1           = 1'b1;
      k1           = TK_EOF;
      n1           = '0;
      mode_nxt     = LM_IDLE;
      dq_nxt       = 1'b0;
      cur_line_nxt = LINE_ONE;
      cur_col_nxt  = COL_ONE;
      pos_nxt      = '0;
      tok_line_nxt = LINE_ONE;
      tok_col_nxt  = COL_ONE;
      tok_off_nxt  = '0;
      tok_len_nxt  = '0;
    end else begin
      unique case (mode_r)
        LM_SLASH: begin
          if (text_byte == CH_STAR) begin
            mode_nxt = LM_COMMENT;
          end else begin
            e0       = 1'b1;
            run_idle = 1'b1;
          end
        end
        LM_COMMENT: begin
          if (text_byte == CH_STAR) mode_nxt = LM_STAR;
        end
        LM_STAR: begin
          if (text_byte == CH_SLASH) mode_nxt = LM_IDLE;
          else if (text_byte != CH_STAR) mode_nxt = LM_COMMENT;
        end
        LM_HASH, LM_AT, LM_NUMBER, LM_IDENT: begin
          if (cont) begin
            tok_len_nxt = len_inc;
          end else begin
            e0       = 1'b1;
            run_idle = 1'b1;
          end
        end
        LM_STRING: begin
          if (quote_hit) begin
            e0       = 1'b1;
            mode_nxt = LM_IDLE;
          end else begin
            tok_len_nxt = len_inc;
            if (text_byte == CH_BSLASH) mode_nxt = LM_ESCAPE;
          end
        end
        LM_ESCAPE: begin
          tok_len_nxt = len_inc;
          mode_nxt    = LM_STRING;
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      // Classify the byte from the idle mode
      if (run_idle) begin
        mode_nxt = LM_IDLE;
        priority if (is_space(text_byte)) begin
          mode_nxt = LM_IDLE;
        end else if (text_byte == CH_LBRACE) begin
          e1 = 1'b1;
          k1 = TK_LBRACE;
        end else if (text_byte == CH_RBRACE) begin
          e1 = 1'b1;
          k1 = TK_RBRACE;
        end else if (text_byte == CH_COLON) begin
          e1 = 1'b1;
          k1 = TK_COLON;
        end else if (text_byte == CH_SEMI) begin
          e1 = 1'b1;
          k1 = TK_SEMI;
        end else if (text_byte == CH_COMMA) begin
          e1 = 1'b1;
          k1 = TK_COMMA;
        end else if ((text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE)) begin
          mode_nxt     = LM_STRING;
          dq_nxt       = (text_byte == CH_DQUOTE);
          tok_line_nxt = cur_line_r;
          tok_col_nxt  = cur_col_r;
          tok_off_nxt  = pos_inc;
          tok_len_nxt  = '0;
        end else if ((text_byte == CH_SLASH) || (text_byte == CH_HASH) ||
                     (text_byte == CH_AT) || is_digit(text_byte) ||
                     is_alpha(text_byte) || (text_byte == CH_MINUS) ||
                     (text_byte == CH_UNDER)) begin
          priority if (text_byte == CH_SLASH) mode_nxt = LM_SLASH;
          else if (text_byte == CH_HASH) mode_nxt = LM_HASH;
          else if (text_byte == CH_AT) mode_nxt = LM_AT;
          else if (is_digit(text_byte)) mode_nxt = LM_NUMBER;
          else mode_nxt = LM_IDENT;
          tok_line_nxt = cur_line_r;
          tok_col_nxt  = cur_col_r;
          tok_off_nxt  = pos_r;
          tok_len_nxt  = OFF_ONE;
        end else begin
          e1 = 1'b1;
          k1 = TK_DELIM;
        end
      end

      // Position tracking applies to every byte
      pos_nxt = pos_inc;
      if (text_byte == CH_NEWLINE) begin
        cur_line_nxt = line_inc;
        cur_col_nxt  = COL_ONE;
      end else begin
        cur_col_nxt  = col_inc;
      end
    end
  end

  // Record to the queue
  assign push     = step && (e0 || e1);
  assign push_rec = {e1, k1, cur_line_r, cur_col_r, o1, n1,
                     e0, k0, tok_line_r, tok_col_r, tok_off_r, tok_len_r};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= LM_IDLE;
      dq_r       <= 1'b0;
      cur_line_r <= LINE_ONE;
      cur_col_r  <= COL_ONE;
      pos_r      <= '0;
      tok_line_r <= LINE_ONE;
      tok_col_r  <= COL_ONE;
      tok_off_r  <= '0;
      tok_len_r  <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      dq_r       <= dq_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      pos_r      <= pos_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      tok_off_r  <= tok_off_nxt;
      tok_len_r  <= tok_len_nxt;
    end
  end

endmodule

### sv/cbt_fifo.sv
// Short queue of token records between the lexer front end and the output back end.
`timescale 1ns / 1ps

module cbt_fifo
  import cbt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CBT_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_FULL);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### sv/cbt_back.sv
// Back end: splits queued records into single tokens behind an output register.
`timescale 1ns / 1ps

module cbt_back
  import cbt_pkg::*;
#(
  parameter int LINE_BITS   = CBT_LINE_BITS,
  parameter int COLUMN_BITS = CBT_COLUMN_BITS,
  parameter int OFFSET_BITS = CBT_OFFSET_BITS,
  localparam int SLOT_W     = 1 + KIND_BITS + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS,
  localparam int REC_W      = 2 * SLOT_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  logic [REC_W-1:0]       head_rec,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   out_token_kind,
  output logic [LINE_BITS-1:0]   out_start_line,
  output logic [COLUMN_BITS-1:0] out_start_column,
  output logic [OFFSET_BITS-1:0] out_text_offset,
  output logic [OFFSET_BITS-1:0] out_text_length,
  output logic                   out_last_of_run
);

  logic [SLOT_W-1:0]      slot0, slot1, pick;
  logic                   v0, v1;
  logic                   out_valid_r, out_valid_nxt;
  logic                   sent0_r, sent0_nxt;
  logic                   last_nxt, load, take0;
  logic [KIND_BITS-1:0]   kind_r;
  logic [LINE_BITS-1:0]   line_r;
  logic [COLUMN_BITS-1:0] col_r;
  logic [OFFSET_BITS-1:0] off_r, len_r;
  logic                   last_r;

  assign slot0 = head_rec[SLOT_W-1:0];
  assign slot1 = head_rec[REC_W-1:SLOT_W];
  assign v0    = slot0[SLOT_W-1];
  assign v1    = slot1[SLOT_W-1];
  assign load  = !out_valid_r || out_ready;
  assign take0 = v0 && !sent0_r;
  assign pick  = take0 ? slot0 : slot1;

  // Choose the next token and decide when the record is used up
  always_comb begin
    out_valid_nxt = out_valid_r;
    sent0_nxt     = sent0_r;
    pop           = 1'b0;
    last_nxt      = 1'b1;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        if (take0) begin
          last_nxt = !v1;
          if (v1) sent0_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          pop       = 1'b1;
          sent0_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent0_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent0_r     <= sent0_nxt;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      {kind_r, line_r, col_r, off_r, len_r} <= pick[SLOT_W-2:0];
      last_r <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = kind_r;
  assign out_start_line   = line_r;
  assign out_start_column = col_r;
  assign out_text_offset  = off_r;
  assign out_text_length  = len_r;
  assign out_last_of_run  = last_r;

endmodule

### tb/sv/css_byte_tokenizer_checker.sv
// Token predictor and comparator that watches both channels of the CSS byte tokenizer.
`timescale 1ns / 1ps

module css_byte_tokenizer_checker
  import cbt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 in_text_byte,
  input  logic                       in_end_of_text,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [KIND_BITS-1:0]       out_token_kind,
  input  logic [CBT_LINE_BITS-1:0]   out_start_line,
  input  logic [CBT_COLUMN_BITS-1:0] out_start_column,
  input  logic [CBT_OFFSET_BITS-1:0] out_text_offset,
  input  logic [CBT_OFFSET_BITS-1:0] out_text_length,
  input  logic                       out_last_of_run,
  output int                         fail_count,
  output int                         pending_count,
  output int                         tokens_checked
);

  localparam int LB = CBT_LINE_BITS;
  localparam int CB = CBT_COLUMN_BITS;
  localparam int OB = CBT_OFFSET_BITS;
  localparam logic [OB-1:0] LEN_ONE  = 1;
  localparam logic [OB-1:0] LEN_ZERO = 0;

  typedef struct packed {
    token_kind_t   kind;
    logic [LB-1:0] line;
    logic [CB-1:0] col;
    logic [OB-1:0] off;
    logic [OB-1:0] len;
    logic          last;
  } token_rec_t;

  // Expected tokens, oldest first
  token_rec_t pending_tokens[$];

  // Lexer state as predicted
  lex_mode_t     mode;
  logic          dquote;
  logic [LB-1:0] cur_line;
  logic [CB-1:0] cur_col;
  logic [OB-1:0] pos;
  logic [LB-1:0] tok_line;
  logic [CB-1:0] tok_col;
  logic [OB-1:0] tok_off;
  logic [OB-1:0] tok_len;

  // Tokens caused by the word being predicted
  token_rec_t word_toks[2];
  int         word_n;

  function automatic logic [LB-1:0] line_inc(input logic [LB-1:0] v);
    return (v == {LB{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [CB-1:0] col_inc(input logic [CB-1:0] v);
    return (v == {CB{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [OB-1:0] off_inc(input logic [OB-1:0] v);
    return (v == {OB{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic letter_byte(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  task automatic clear_model();
    mode     = LM_IDLE;
    dquote   = 1'b0;
    cur_line = 1;
    cur_col  = 1;
    pos      = 0;
    tok_line = 1;
    tok_col  = 1;
    tok_off  = 0;
    tok_len  = 0;
  endtask

  task automatic add_tok(input token_kind_t k, input logic [LB-1:0] l, input logic [CB-1:0] c,
                         input logic [OB-1:0] o, input logic [OB-1:0] n);
    token_rec_t t;
    t.kind = k;
    t.line = l;
    t.col  = c;
    t.off  = o;
    t.len  = n;
    t.last = 1'b0;
    word_toks[word_n] = t;
    word_n++;
  endtask

  task automatic add_held(input token_kind_t k);
    add_tok(k, tok_line, tok_col, tok_off, tok_len);
  endtask

  task automatic open_tok(input lex_mode_t m, input logic [OB-1:0] o, input logic [OB-1:0] n);
    mode     = m;
    tok_line = cur_line;
    tok_col  = cur_col;
    tok_off  = o;
    tok_len  = n;
  endtask

  // A byte seen with nothing pending
  task automatic lex_fresh(input logic [7:0] b);
    mode = LM_IDLE;
    if (!blank_byte(b)) begin
      case (b)
        CH_LBRACE: add_tok(TK_LBRACE, cur_line, cur_col, pos, LEN_ONE);
        CH_RBRACE: add_tok(TK_RBRACE, cur_line, cur_col, pos, LEN_ONE);
        CH_COLON:  add_tok(TK_COLON, cur_line, cur_col, pos, LEN_ONE);
        CH_SEMI:   add_tok(TK_SEMI, cur_line, cur_col, pos, LEN_ONE);
        CH_COMMA:  add_tok(TK_COMMA, cur_line, cur_col, pos, LEN_ONE);
        CH_SLASH:  open_tok(LM_SLASH, pos, LEN_ONE);
        CH_HASH:   open_tok(LM_HASH, pos, LEN_ONE);
        CH_AT:     open_tok(LM_AT, pos, LEN_ONE);
        CH_DQUOTE, CH_SQUOTE: begin
          // string text starts after the quote
          open_tok(LM_STRING, off_inc(pos), LEN_ZERO);
          dquote = (b == CH_DQUOTE);
        end
        default: begin
          if (digit_byte(b)) open_tok(LM_NUMBER, pos, LEN_ONE);
          else if (letter_byte(b) || b == CH_MINUS || b == CH_UNDER)
            open_tok(LM_IDENT, pos, LEN_ONE);
          else add_tok(TK_DELIM, cur_line, cur_col, pos, LEN_ONE);
        end
      endcase
    end
  endtask

  // Grow the held token, or emit it and relex the byte
  task automatic grow_or_close(input logic [7:0] b, input logic grow, input token_kind_t k);
    if (grow) begin
      tok_len = off_inc(tok_len);
    end else begin
      add_held(k);
      lex_fresh(b);
    end
  endtask

  task automatic lex_word(input logic [7:0] b, input logic eot);
    logic word_ch;
    word_n  = 0;
    word_ch = digit_byte(b) || letter_byte(b);
    if (eot) begin
      // flush whatever is held, then end of file
      case (mode)
        LM_SLASH:  add_held(TK_DELIM);
        LM_HASH:   add_held(TK_HASH);
        LM_AT:     add_held(TK_AT);
        LM_NUMBER: add_held(TK_NUMBER);
        LM_IDENT:  add_held(TK_IDENT);
        LM_STRING, LM_ESCAPE: add_held(TK_STRING);
        default: ;
      endcase
      add_tok(TK_EOF, cur_line, cur_col, pos, LEN_ZERO);
      clear_model();
    end else begin
      case (mode)
        LM_SLASH: begin
          if (b == CH_STAR) begin
            mode = LM_COMMENT;
          end else begin
            add_held(TK_DELIM);
            lex_fresh(b);
          end
        end
        LM_COMMENT: if (b == CH_STAR) mode = LM_STAR;
        LM_STAR: begin
          if (b == CH_SLASH) mode = LM_IDLE;
          else if (b != CH_STAR) mode = LM_COMMENT;
        end
        LM_HASH:   grow_or_close(b, word_ch || b == CH_MINUS || b == CH_UNDER, TK_HASH);
        LM_AT:     grow_or_close(b, word_ch || b == CH_MINUS, TK_AT);
        LM_NUMBER: grow_or_close(b, word_ch || b == CH_DOT || b == CH_PERCENT, TK_NUMBER);
        LM_IDENT:  grow_or_close(b, word_ch || b == CH_MINUS || b == CH_UNDER, TK_IDENT);
        LM_STRING: begin
          if (b == (dquote ? CH_DQUOTE : CH_SQUOTE)) begin
            add_held(TK_STRING);
            mode = LM_IDLE;
          end else begin
            tok_len = off_inc(tok_len);
            if (b == CH_BSLASH) mode = LM_ESCAPE;
          end
        end
        LM_ESCAPE: begin
          tok_len = off_inc(tok_len);
          mode    = LM_STRING;
        end
        default: lex_fresh(b);
      endcase
      // position moves on every byte
      pos = off_inc(pos);
      if (b == CH_NEWLINE) begin
        cur_line = line_inc(cur_line);
        cur_col  = 1;
      end else begin
        cur_col = col_inc(cur_col);
      end
    end
    if (word_n > 0) word_toks[word_n-1].last = 1'b1;
    for (int i = 0; i < word_n; i++) pending_tokens.insert(pending_tokens.size(), word_toks[i]);
  endtask

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp)
      report($sformatf("token %0d %s: got %0d expected %0d", tokens_checked, name, got, exp));
  endtask

  task automatic check_token();
    token_rec_t want;
    if (pending_tokens.size() == 0) begin
      report($sformatf("token of kind %0d arrived with none expected", out_token_kind));
    end else begin
      want = pending_tokens.pop_front();
      check_field("kind", 32'(out_token_kind), 32'(want.kind));
      check_field("start_line", 32'(out_start_line), 32'(want.line));
      check_field("start_column", 32'(out_start_column), 32'(want.col));
      check_field("text_offset", 32'(out_text_offset), 32'(want.off));
      check_field("text_length", 32'(out_text_length), 32'(want.len));
      check_field("last_of_run", 32'(out_last_of_run), 32'(want.last));
    end
    tokens_checked++;
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      pending_tokens.delete();
      fail_count     = 0;
      tokens_checked = 0;
    end else begin
      if (out_valid && out_ready) check_token();
      if (in_valid && in_ready) lex_word(in_text_byte, in_end_of_text);
    end
    pending_count <= pending_tokens.size();
  end

endmodule

### tb/sv/css_byte_tokenizer_top_tb.sv
// Testbench top for the CSS byte tokenizer: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module css_byte_tokenizer_top_tb;
  import cbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_WORDS    = 470;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_text_byte = 8'h00;
  logic                       in_end_of_text = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [KIND_BITS-1:0]       out_token_kind;
  logic [CBT_LINE_BITS-1:0]   out_start_line;
  logic [CBT_COLUMN_BITS-1:0] out_start_column;
  logic [CBT_OFFSET_BITS-1:0] out_text_offset;
  logic [CBT_OFFSET_BITS-1:0] out_text_length;
  logic                       out_last_of_run;

  int fail_count;
  int pending_count;
  int tokens_checked;

  int words_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  string ID_LEAD  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_";
  string ID_BODY  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
  string AT_BODY  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
  string DIGITS   = "0123456789";
  string NUM_BODY = "0123456789.%pxemPX";
  string PUNCT    = "{}:;,";

  logic [7:0] blank_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  always #5 clk = ~clk;

  css_byte_tokenizer_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_start_line  (out_start_line),
    .out_start_column(out_start_column),
    .out_text_offset (out_text_offset),
    .out_text_length (out_text_length),
    .out_last_of_run (out_last_of_run)
  );

  css_byte_tokenizer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_start_line  (out_start_line),
    .out_start_column(out_start_column),
    .out_text_offset (out_text_offset),
    .out_text_length (out_text_length),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .tokens_checked  (tokens_checked)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no traffic for %0d cycles, %0d tokens outstanding",
                 WATCHDOG_LIMIT, pending_count);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Mostly from the set, now and then any byte
  function automatic logic [7:0] pick_body(input string s);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return pick(s);
  endfunction

  // One word on the input channel; called and returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // One random lexical chunk: mostly well-formed tokens, some noise
  task automatic send_chunk();
    int         sel;
    int         n;
    logic [7:0] q;
    sel = $urandom_range(0, 99);
    n   = $urandom_range(0, 6);
    if (sel < 14) begin
      send_word(pick(ID_LEAD), 1'b0);
      repeat (n) send_word(pick_body(ID_BODY), 1'b0);
    end else if (sel < 21) begin
      send_word(CH_HASH, 1'b0);
      repeat (n) send_word(pick_body(ID_BODY), 1'b0);
    end else if (sel < 27) begin
      send_word(CH_AT, 1'b0);
      repeat (n) send_word(pick_body(AT_BODY), 1'b0);
    end else if (sel < 37) begin
      send_word(pick(DIGITS), 1'b0);
      repeat (n) send_word(pick_body(NUM_BODY), 1'b0);
    end else if (sel < 47) begin
      // quoted string with escapes, stray quotes and newlines
      q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
      send_word(q, 1'b0);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          send_word(CH_BSLASH, 1'b0);
          send_word(($urandom_range(0, 1) == 1) ? q : 8'($urandom_range(0, 255)), 1'b0);
        end else if (sel < 25) begin
          send_word((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
        end else if (sel < 30) begin
          send_word(CH_NEWLINE, 1'b0);
        end else begin
          send_word(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      if ($urandom_range(0, 9) != 0) send_word(q, 1'b0);
    end else if (sel < 54) begin
      // comment, stars common inside
      send_text("/*");
      repeat (n) send_word(($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(0, 255)),
                           1'b0);
      if ($urandom_range(0, 9) != 0) send_text("*/");
    end else if (sel < 70) begin
      send_word(pick(PUNCT), 1'b0);
    end else if (sel < 82) begin
      send_word(blank_bytes[$urandom_range(0, 5)], 1'b0);
    end else if (sel < 85) begin
      send_word(CH_SLASH, 1'b0);
    end else if (sel < 98) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_end();
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct);
    int start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start         = words_sent;
    while (words_sent - start < PHASE_WORDS) send_chunk();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every token kind but identifier, escapes, comment close after stars,
    // lone slash before another token, high bytes, end marker flushes
    send_idle_pct = 30;
    recv_idle_pct = 66;
    send_text("#a_-{@-:1.%}");
    send_word(CH_DQUOTE, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_DQUOTE, 1'b0);
    send_word(CH_SQUOTE, 1'b0);
    send_word(CH_DQUOTE, 1'b0);
    send_text("/;/***/");
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(CH_NEWLINE, 1'b0);
    send_text(",'q");
    send_end();
    send_text("/*");
    send_end();
    send_text("/");
    send_end();

    run_phase(30, 66);
    run_phase(66, 30);

    // No idling; receiver holds off while the sender keeps pushing
    hold_req++;
    run_phase(0, 0);

    // Flush whatever token is still held
    send_end();

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d words: directed tokens, three idle mixes, a long receiver hold-off",
             words_sent);
    $display("with the queue full; %0d tokens compared, %0d mismatches",
             tokens_checked, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/cbt_pkg.sv
sv/cbt_front.sv
sv/cbt_fifo.sv
sv/cbt_back.sv
sv/css_byte_tokenizer_top.sv
tb/sv/css_byte_tokenizer_checker.sv
tb/sv/css_byte_tokenizer_top_tb.sv
